/* rtl/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic {
    OP_ABSORB   = 1'b0,
    OP_FINALIZE = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic        finalize;
    logic [31:0] word;
    logic [3:0]  word_pos;
    logic        block_full;
    logic [63:0] bit_len;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* rtl/sha_front.sv */
// Front end: packs message bytes into words, counts length, issues commands.
module sha_front import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_item,
  input  logic     in_push,
  output logic     in_full,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_ready
);

  logic [60:0] count_r, count_nxt;
  logic [23:0] part_r, part_nxt;
  logic        take;
  logic [1:0]  lane;

  assign lane    = count_r[1:0];
  assign in_full = !cmd_ready;
  assign take    = in_push && cmd_ready;

  // A command goes out on finalize or when a word completes.
  always_comb begin
    cmd.finalize   = (in_item.operation == OP_FINALIZE);
    cmd.word       = {part_r, in_item.data_byte};
    cmd.word_pos   = count_r[5:2];
    cmd.block_full = (count_r[5:0] == 6'd63);
    cmd.bit_len    = {count_r, 3'b000};
    cmd_valid      = take && (cmd.finalize || lane == 2'd3);
  end

  // Partial word and byte count.
  always_comb begin
    count_nxt = count_r;
    part_nxt  = part_r;
    if (take) begin
      if (in_item.operation == OP_FINALIZE) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_r + 61'd1;
        case (lane)
          2'd0:    part_nxt = {in_item.data_byte, 16'h0};
          2'd1:    part_nxt = {part_r[23:16], in_item.data_byte, 8'h0};
          2'd2:    part_nxt = {part_r[23:8], in_item.data_byte};
          default: part_nxt = part_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    part_r <= part_nxt;
  end

endmodule

/* rtl/sha_queue.sv */
// Small command queue between front and back.
module sha_queue import sha_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t wr_data,
  input  logic wr_en,
  output logic wr_ready,
  output cmd_t rd_data,
  output logic rd_valid,
  input  logic rd_en
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t           mem_r [Depth];
  logic [Aw-1:0]  wp_r, rp_r;
  logic [Aw:0]    cnt_r;

  assign wr_ready = (cnt_r != (Aw+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
    inc = (p == Aw'(Depth - 1)) ? '0 : p + Aw'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= inc(wp_r);
      if (rd_en) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

/* rtl/sha_back.sv */
// Back end: schedule, one compression round per cycle, padding and digest output.
module sha_back import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  back_state_t  state_r, state_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   rnd_r;
  logic [3:0]   fill_r;      // next word slot to fill during padding
  logic         fin_r;       // finalize in progress
  logic         last_blk_r;  // the block in flight holds the length
  logic [63:0]  len_r;
  logic [2:0]   oidx_r;
  logic         ovalid_r;
  out_item_t    obuf_r;

  logic [31:0] w_cur, w_new, t1, t2;
  logic        obuf_free;

  assign obuf_free = !ovalid_r || out_pop;
  assign out_item  = obuf_r;
  assign out_empty = !ovalid_r;
  assign w_cur     = w_r[0];
  assign w_new     = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundK[rnd_r] + w_cur;
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Next state. A finalize whose 0x80 lands in the last word needs no
  // padding in this block and goes straight to compression.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.finalize) state_nxt = (cmd.word_pos == 4'd15) ? ST_ROUND : ST_PAD;
          else if (cmd.block_full) state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (last_blk_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_PAD: if (fill_r == 4'd15) state_nxt = ST_ROUND;
      ST_EMIT: if (obuf_free && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs toward the queue.
  always_comb begin
    cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !cmd.finalize) w_r[cmd.word_pos] <= cmd.word;
        if (cmd_valid && cmd.finalize) begin
          // The 0x80 byte lands after the bytes already held in the word.
          case (cmd.bit_len[4:3])
            2'd0:    w_r[cmd.word_pos] <= 32'h80000000;
            2'd1:    w_r[cmd.word_pos] <= {cmd.word[31:24], 24'h800000};
            2'd2:    w_r[cmd.word_pos] <= {cmd.word[31:16], 16'h8000};
            default: w_r[cmd.word_pos] <= {cmd.word[31:8], 8'h80};
          endcase
          len_r <= cmd.bit_len;
        end
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      ST_PAD: begin
        if (last_blk_r && fill_r == 4'd14) w_r[14] <= len_r[63:32];
        else if (last_blk_r && fill_r == 4'd15) w_r[15] <= len_r[31:0];
        else w_r[fill_r] <= 32'h0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_EMIT: begin
        if (obuf_free) begin
          obuf_r.digest_word <= h_r[oidx_r];
          obuf_r.word_index  <= oidx_r;
          obuf_r.last_word   <= (oidx_r == 3'd7);
        end
      end
      default: ;
    endcase
  end

  // Control registers and chaining values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rnd_r      <= '0;
      fill_r     <= '0;
      fin_r      <= 1'b0;
      last_blk_r <= 1'b0;
      oidx_r     <= '0;
      ovalid_r   <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[255-32*i -: 32];
    end else begin
      state_r <= state_nxt;
      // The output buffer refills while emitting, otherwise a pop empties it.
      if (state_r == ST_EMIT && obuf_free) ovalid_r <= 1'b1;
      else if (out_pop) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          rnd_r <= '0;
          if (cmd_valid && cmd.finalize) begin
            fin_r      <= 1'b1;
            fill_r     <= cmd.word_pos + 4'd1;
            // Length fits when 0x80 sits at byte 55 or earlier.
            last_blk_r <= (cmd.bit_len[8:3] < 6'd56);
          end
        end
        ST_ROUND: rnd_r <= rnd_r + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (fin_r && !last_blk_r) begin
            last_blk_r <= 1'b1;
            fill_r     <= '0;
          end
        end
        ST_PAD: begin
          fill_r <= fill_r + 4'd1;
          rnd_r  <= '0;
        end
        ST_EMIT: begin
          if (obuf_free) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              fin_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= InitHash[255-32*i -: 32];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/sha256_stream_hasher_core.sv */
// Top level of the SHA-256 stream hasher.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_push/in_full  | in_item (operation, data_byte)
//  out_    | output    | out_pop/out_empty| out_item (digest_word, word_index, last_word)
//
// Each absorbed byte is packed in the front; every fourth byte moves a word into
// the back through a short queue. The back takes in words only while idle, then
// runs the compression rounds and one add step per full block, and takes no new
// word while a block is compressing.
// Finalize takes padding, one or two compressions and eight
// digest words. Reset is synchronous and restores the initial hash values.
// A stalled output holds the back; the front keeps taking bytes until the queue fills.
module sha256_stream_hasher_core import sha_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      in_push,
  output logic      in_full,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  cmd_t fcmd, qcmd;
  logic fvalid, qready, qvalid, qpop;

  sha_front u_front (
    .clk, .rst_n, .in_item, .in_push, .in_full,
    .cmd(fcmd), .cmd_valid(fvalid), .cmd_ready(qready)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_data(fcmd), .wr_en(fvalid), .wr_ready(qready),
    .rd_data(qcmd), .rd_valid(qvalid), .rd_en(qpop)
  );

  sha_back u_back (
    .clk, .rst_n, .cmd(qcmd), .cmd_valid(qvalid), .cmd_pop(qpop),
    .out_item, .out_empty, .out_pop
  );

endmodule

/* rtl/sha_checker.sv */
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
module sha_checker import sha_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input out_item_t out_item,
  input logic      out_empty,
  input logic      out_pop
);

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while stalled");

  // Word indexes count up one per delivered transaction.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && out_item.word_index != 3'd7 ##1 !out_empty |->
    out_item.word_index == $past(out_item.word_index) + 3'd1)
    else $error("digest word out of order");

  // The last flag marks index seven only.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.last_word == (out_item.word_index == 3'd7))
    else $error("last flag mismatch");

  // Nothing appears on the result side right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result after reset");

  // The input side is open right after reset.
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
  .clk, .rst_n, .in_full, .out_item, .out_empty, .out_pop
);
